### hw/rtl/tensor_pad_index_generator_assert.svh
// Assertion macros used by the checker file.
`ifndef TENSOR_PAD_INDEX_GENERATOR_ASSERT_SVH
`define TENSOR_PAD_INDEX_GENERATOR_ASSERT_SVH

// Checked only while out of reset.
`define TPIG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TPIG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tpig_pkg.sv
package tpig_pkg;

    localparam int MAX_AXES    = 4;
    localparam int DIM_BITS    = 16;
    localparam int COORD_BITS  = DIM_BITS + 2;
    localparam int CNT_BITS    = 32;
    localparam int CFG_BITS    = 64;
    localparam int FILL_BITS   = 32;
    localparam int AXC_BITS    = 3;
    localparam int ADDR_BITS   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [ADDR_BITS-1:0] {
        REG_AXIS_COUNT  = 3'd0,
        REG_SOURCE_DIMS = 3'd1,
        REG_PAD_BEFORE  = 3'd2,
        REG_PAD_AFTER   = 3'd3,
        REG_FILL_BITS   = 3'd4
    } cfg_reg_t;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    // Per-axis region bounds derived from the configuration registers
    typedef struct packed {
        logic [MAX_AXES-1:0]                 in_use;
        logic [MAX_AXES-1:0][DIM_BITS-1:0]   lo;
        logic [MAX_AXES-1:0][DIM_BITS:0]     hi;
        logic [MAX_AXES-1:0][COORD_BITS-1:0] last_coord;
        logic [FILL_BITS-1:0]                fill;
    } bounds_t;

    typedef struct packed {
        logic restart;
        logic drop;
    } job_t;

    typedef struct packed {
        logic                 is_pad;
        logic [CNT_BITS-1:0]  source_index;
        logic [CNT_BITS-1:0]  dest_index;
        logic [FILL_BITS-1:0] fill_value;
        logic                 last;
    } rsp_beat_t;

    function automatic logic [DIM_BITS-1:0] packed_field(logic [CFG_BITS-1:0] word, int axis);
        logic [DIM_BITS-1:0] f;
        f = '0;
        if ((axis + 1) * DIM_BITS <= CFG_BITS)
        begin
            f = word[axis*DIM_BITS +: DIM_BITS];
        end
        return f;
    endfunction

endpackage

### hw/rtl/tpig_req_if.sv
interface tpig_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

### hw/rtl/tpig_rsp_if.sv
interface tpig_rsp_if;
    import tpig_pkg::*;

    logic      valid;
    logic      ready;
    rsp_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tpig_cfg_if.sv
interface tpig_cfg_if;
    import tpig_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] addr;
    logic [CFG_BITS-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

### hw/rtl/tpig_queue.sv
module tpig_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tpig_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tpig_pkg::job_t pop_data
);
    import tpig_pkg::*;

    job_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] n;
        n = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QPTR_BITS'(p + 1'b1);
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= QCNT_BITS'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= QCNT_BITS'(count_reg - 1'b1);
            end
        end
    end
endmodule

### hw/rtl/tpig_front.sv
module tpig_front (
    input  logic            clk,
    input  logic            rst_n,
    tpig_cfg_if.sink        cfg,
    tpig_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output tpig_pkg::job_t  push_data,
    output tpig_pkg::bounds_t bounds
);
    import tpig_pkg::*;

    logic [AXC_BITS-1:0]  axis_count_reg;
    logic [CFG_BITS-1:0]  source_dims_reg;
    logic [CFG_BITS-1:0]  pad_before_reg;
    logic [CFG_BITS-1:0]  pad_after_reg;
    logic [FILL_BITS-1:0] fill_bits_reg;
    logic                 empty_axis;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg  <= AXC_BITS'(1);
            source_dims_reg <= '0;
            pad_before_reg  <= '0;
            pad_after_reg   <= '0;
            fill_bits_reg   <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.addr))
                REG_AXIS_COUNT:  axis_count_reg  <= cfg.data[AXC_BITS-1:0];
                REG_SOURCE_DIMS: source_dims_reg <= cfg.data;
                REG_PAD_BEFORE:  pad_before_reg  <= cfg.data;
                REG_PAD_AFTER:   pad_after_reg   <= cfg.data;
                REG_FILL_BITS:   fill_bits_reg   <= cfg.data[FILL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Axis 0 is always in use; a count of zero behaves as one
    always_comb
    begin
        logic [DIM_BITS-1:0]   pb;
        logic [DIM_BITS-1:0]   sd;
        logic [DIM_BITS-1:0]   pa;
        logic [COORD_BITS-1:0] len;
        bounds = '0;
        empty_axis = 1'b0;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            pb  = packed_field(pad_before_reg, a);
            sd  = packed_field(source_dims_reg, a);
            pa  = packed_field(pad_after_reg, a);
            len = COORD_BITS'(pb) + COORD_BITS'(sd) + COORD_BITS'(pa);
            bounds.in_use[a]     = (a == 0) || (int'(axis_count_reg) > a);
            bounds.lo[a]         = pb;
            bounds.hi[a]         = (DIM_BITS+1)'(pb) + (DIM_BITS+1)'(sd);
            bounds.last_coord[a] = COORD_BITS'(len - 1'b1);
            if (bounds.in_use[a] && (len == '0))
            begin
                empty_axis = 1'b1;
            end
        end
        bounds.fill = fill_bits_reg;
    end

    // Tag each beat: an empty padded shape yields no element
    assign push_valid        = req.valid;
    assign req.ready         = push_ready;
    assign push_data.restart = req.restart;
    assign push_data.drop    = empty_axis;
endmodule

### hw/rtl/tpig_back.sv
module tpig_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  tpig_pkg::job_t    pop_data,
    input  tpig_pkg::bounds_t bounds,
    tpig_rsp_if.source        rsp
);
    import tpig_pkg::*;

    coord_t    coord_reg [MAX_AXES];
    coord_t    coord_next [MAX_AXES];
    cnt_t      src_reg;
    cnt_t      src_next;
    cnt_t      dst_reg;
    cnt_t      dst_next;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_beat_t rsp_data_reg;
    rsp_beat_t beat;
    logic      out_free;
    logic      step;
    logic      emit;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign pop_ready = out_free || pop_data.drop;
    assign step      = pop_valid && pop_ready;
    assign emit      = step && !pop_data.drop;

    always_comb
    begin
        coord_t c;
        cnt_t   src_eff;
        cnt_t   dst_eff;
        logic   pad;
        logic   at_end;
        logic   carry;
        logic   wrap;
        pad      = 1'b0;
        at_end   = 1'b1;
        carry    = 1'b1;
        src_eff  = pop_data.restart ? '0 : src_reg;
        dst_eff  = pop_data.restart ? '0 : dst_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            coord_next[a] = coord_reg[a];
        end
        // Ripple the carry from the fastest axis towards axis 0
        for (int a = MAX_AXES - 1; a >= 0; a--)
        begin
            c    = pop_data.restart ? '0 : coord_reg[a];
            wrap = (c >= bounds.last_coord[a]);
            coord_next[a] = c;
            if (bounds.in_use[a])
            begin
                if ((c < COORD_BITS'(bounds.lo[a])) || (c >= COORD_BITS'(bounds.hi[a])))
                begin
                    pad = 1'b1;
                end
                if (!wrap)
                begin
                    at_end = 1'b0;
                end
                if (carry && !pop_data.drop)
                begin
                    coord_next[a] = wrap ? '0 : COORD_BITS'(c + 1'b1);
                end
                carry = carry && wrap;
            end
        end
        if (pop_data.drop)
        begin
            src_next = src_eff;
            dst_next = dst_eff;
        end
        else if (at_end)
        begin
            src_next = '0;
            dst_next = '0;
        end
        else
        begin
            src_next = (!pad && (src_eff != '1)) ? CNT_BITS'(src_eff + 1'b1) : src_eff;
            dst_next = (dst_eff != '1) ? CNT_BITS'(dst_eff + 1'b1) : dst_eff;
        end
        beat.is_pad       = pad;
        beat.source_index = pad ? '0 : src_eff;
        beat.dest_index   = dst_eff;
        beat.fill_value   = pad ? bounds.fill : '0;
        beat.last         = at_end;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < MAX_AXES; a++)
            begin
                coord_reg[a] <= '0;
            end
            src_reg       <= '0;
            dst_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                for (int a = 0; a < MAX_AXES; a++)
                begin
                    coord_reg[a] <= coord_next[a];
                end
                src_reg <= src_next;
                dst_reg <= dst_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the beat while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_data_reg <= beat;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;
endmodule

### hw/rtl/tensor_pad_index_generator.sv
// Padded-tensor index generator.
// cfg: register writes (index, 64-bit data), always ready. Write only while idle:
//   axis_count, source_dims, pad_before, pad_after, fill_bits.
// req: one beat per element; restart = 1 begins a new pass at element zero.
// rsp: one beat per element with is_pad, source_index, dest_index, fill_value, last.
//   If any axis in use has a padded length of zero, a request gives no beat.
// A request beat passes through a queue entry and then the output register to reach rsp.
// Throughput: one element per cycle while rsp is ready; the back end's combinational
//   coordinate step (compare and carry across all axes) sets that figure.
// A two-entry queue sits between the request side and the stepper, and the
//   response sits in an output register, so a new request is taken while a
//   finished beat waits. When rsp stalls, the queue fills and req.ready drops
//   once two beats wait behind the held response.
// Reset clears coordinates and counters, sets axis_count to one and the other
//   registers to zero; req.ready is high once reset is released.
module tensor_pad_index_generator (
    input  logic       clk,
    input  logic       rst_n,
    tpig_cfg_if.sink   cfg,
    tpig_req_if.sink   req,
    tpig_rsp_if.source rsp
);
    import tpig_pkg::*;

    logic    push_valid;
    logic    push_ready;
    job_t    push_data;
    logic    pop_valid;
    logic    pop_ready;
    job_t    pop_data;
    bounds_t bounds;

    tpig_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .bounds     (bounds)
    );

    tpig_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tpig_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .bounds    (bounds),
        .rsp       (rsp)
    );
endmodule

### hw/rtl/tpig_checker.sv
`include "tensor_pad_index_generator_assert.svh"

module tpig_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input tpig_pkg::rsp_beat_t rsp_data
);
    import tpig_pkg::*;

    logic [CNT_BITS-1:0] pend_reg;
    logic                after_last_reg;
    logic                req_beat;
    logic                rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    // Requests taken but not yet answered; dropped requests stay counted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            after_last_reg <= 1'b1;
        end
        else
        begin
            if (req_beat && !rsp_beat)
            begin
                pend_reg <= CNT_BITS'(pend_reg + 1'b1);
            end
            else if (rsp_beat && !req_beat)
            begin
                pend_reg <= CNT_BITS'(pend_reg - 1'b1);
            end
            if (rsp_beat)
            begin
                after_last_reg <= rsp_data.last;
            end
        end
    end

    `TPIG_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response beat changed while stalled")
    `TPIG_ASSERT(a_no_invented_beat, rsp_beat |-> pend_reg != '0, "response beat without a pending request")
    `TPIG_ASSERT(a_pass_starts_at_zero, rsp_beat && after_last_reg |-> rsp_data.dest_index == '0, "pass did not start at destination zero")
    `TPIG_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !rsp_valid, "response valid right after reset")
endmodule

bind tensor_pad_index_generator tpig_checker u_tpig_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
